FILE: rtl/isq_pkg.sv
// ----------------------------------------------------------------------------
// isq_pkg: shared types and codes for the indexed sequence store
// Operation and status codes, plus the fixed field widths of the word.
// ----------------------------------------------------------------------------
package isq_pkg;

  localparam int OP_W     = 4;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef logic [OP_W-1:0]          op_t;
  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [COUNT_W-1:0]       count_t;

  // Operation codes
  localparam op_t OP_PUSH_BACK  = 4'd0;
  localparam op_t OP_PUSH_FRONT = 4'd1;
  localparam op_t OP_POP_BACK   = 4'd2;
  localparam op_t OP_POP_FRONT  = 4'd3;
  localparam op_t OP_INSERT     = 4'd4;
  localparam op_t OP_READ       = 4'd5;
  localparam op_t OP_DELETE     = 4'd6;
  localparam op_t OP_WRITE      = 4'd7;
  localparam op_t OP_CLEAR      = 4'd8;
  localparam op_t OP_SIZE       = 4'd9;

  // Status codes
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

endpackage

FILE: rtl/indexed_sequence_store.sv
// Sequence (accept to result): insert/push walk the moved entries through
//   S_RD and S_WR, then S_PUT; delete/pop walk them through S_RD and S_WR;
//   read passes S_RWAIT; all end in S_DONE, held there by any output stall.
//   A new word is taken once the sequencer is back in idle. One shared index
//   adder walks the memory, one entry read in S_RD and written in S_WR per step;
//   memory has no reset; count, state, del_r, out_valid sync-reset on rst_n low.
// ----------------------------------------------------------------------------
// indexed_sequence_store: bounded ordered list with 1-based positions
// Push, pop, insert, read, delete, write, clear and size on a simple dual-port
// element memory, shifting entries one at a time under a sequencer.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  isq_pkg::op_t      in_operation,
  input  isq_pkg::pos_t     in_position,
  input  isq_pkg::data_t    in_data_in,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output isq_pkg::data_t    out_data_out,
  output isq_pkg::status_t  out_status,
  output isq_pkg::count_t   out_count
);

  import isq_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_PUT   = 3'd3;
  localparam logic [2:0] S_RWAIT = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   idx_r, idx_nxt;
  logic [AW-1:0]   at_r, at_nxt;
  logic            del_r, del_nxt;
  data_t           val_r, val_nxt;
  status_t         status_r, status_nxt;
  data_t           data_r, data_nxt;

  logic            out_valid_r, out_valid_nxt;
  data_t           out_data_r;
  status_t         out_status_r;
  count_t          out_count_r;

  // Element memory
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [AW-1:0]     mem_ra;
  logic [DATA_W-1:0] mem_wd;

  logic            accept;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] idx_ext;
  logic            full;
  logic            empty;
  logic            in_range;
  logic [AW-1:0]   pos_idx;
  logic [AW-1:0]   cnt_idx;
  logic [AW-1:0]   src_idx;
  logic            out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  assign pos_ext  = CMPW'(in_position);
  assign cnt_ext  = CMPW'(count_r);
  assign idx_ext  = CMPW'(idx_r);
  assign full     = (count_r >= CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign in_range = (pos_ext >= CMPW'(1)) && (pos_ext <= cnt_ext);
  assign pos_idx  = AW'(pos_ext - CMPW'(1));
  assign cnt_idx  = AW'(count_r);

  // shared index adder: neighbor slot for the shift walk
  assign src_idx  = del_r ? (idx_r + AW'(1)) : (idx_r - AW'(1));

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer and operation decode
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    at_nxt     = at_r;
    del_nxt    = del_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    mem_we     = 1'b0;
    mem_wa     = idx_r;
    mem_wd     = rd_data_r;
    mem_ra     = src_idx;

    case (state_r)
      S_IDLE: begin
        mem_ra = pos_idx;
        if (accept) begin
          status_nxt = ST_OK;
          data_nxt   = '0;
          val_nxt    = in_data_in;
          state_nxt  = S_DONE;
          case (in_operation)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                del_nxt   = 1'b0;
                idx_nxt   = cnt_idx;
                count_nxt = count_r + CW'(1);
                state_nxt = S_RD;
                if (in_operation == OP_PUSH_BACK) begin
                  at_nxt = cnt_idx;
                end else if (in_operation == OP_PUSH_FRONT) begin
                  at_nxt = '0;
                end else if (pos_ext > cnt_ext) begin
                  at_nxt = cnt_idx;
                end else if (pos_ext <= CMPW'(1)) begin
                  at_nxt = '0;
                end else begin
                  at_nxt = pos_idx;
                end
              end
            end
            OP_POP_BACK, OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else begin
                del_nxt   = 1'b1;
                idx_nxt   = (in_operation == OP_POP_BACK) ? AW'(count_r - CW'(1)) : '0;
                count_nxt = count_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            OP_DELETE: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (!in_range) begin
                status_nxt = ST_RANGE;
              end else begin
                del_nxt   = 1'b1;
                idx_nxt   = pos_idx;
                count_nxt = count_r - CW'(1);
                state_nxt = S_RD;
              end
            end
            OP_READ: begin
              if (in_range) begin
                state_nxt = S_RWAIT;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            OP_WRITE: begin
              if (in_range) begin
                mem_we = 1'b1;
                mem_wa = pos_idx;
                mem_wd = in_data_in;
              end else begin
                status_nxt = ST_RANGE;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // check walk end, else fetch the neighbor entry
      S_RD: begin
        if (del_r) begin
          if (idx_ext == cnt_ext) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_WR;
          end
        end else begin
          if (idx_r == at_r) begin
            state_nxt = S_PUT;
          end else begin
            state_nxt = S_WR;
          end
        end
      end

      // move fetched word into the current slot
      S_WR: begin
        mem_we    = 1'b1;
        mem_wa    = idx_r;
        mem_wd    = rd_data_r;
        idx_nxt   = src_idx;
        state_nxt = S_RD;
      end

      // drop the new value into the opened slot
      S_PUT: begin
        mem_we    = 1'b1;
        mem_wa    = at_r;
        mem_wd    = val_r;
        state_nxt = S_DONE;
      end

      S_RWAIT: begin
        data_nxt  = rd_data_r;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      del_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      del_r       <= del_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    at_r     <= at_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    if (state_r == S_DONE && out_free) begin
      out_data_r   <= data_r;
      out_status_r <= status_r;
      out_count_r  <= cnt_ext[COUNT_W-1:0];
    end
  end

  // Element memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

endmodule
